// ----- sv/rrip_pkg.sv -----
// shared constants, types and command codes for the rrip replacement core
package rrip_pkg;

   // cache geometry
   localparam int SET_COUNT = 1024;
   localparam int WAY_COUNT = 16;
   localparam int RRPV_BITS = 2;

   // field widths of the request and response beats
   localparam int OP_W  = 2;
   localparam int SET_W = 10;
   localparam int WAY_W = 4;

   // derived widths
   localparam int SET_AW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   localparam int WAY_AW = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam int ROW_W  = WAY_COUNT * RRPV_BITS;

   typedef logic [RRPV_BITS-1:0] rrpv_val_type;
   typedef logic [ROW_W-1:0]     row_type;
   typedef logic [SET_AW-1:0]    set_addr_type;
   typedef logic [WAY_AW-1:0]    way_addr_type;
   typedef logic [WAY_COUNT-1:0] way_mask_type;

   localparam rrpv_val_type RRPV_MAX  = '1;
   localparam rrpv_val_type RRPV_FILL = RRPV_MAX - rrpv_val_type'(1);

   // request operation codes
   localparam logic [OP_W-1:0] OP_VICTIM = 2'd0;
   localparam logic [OP_W-1:0] OP_HIT    = 2'd1;
   localparam logic [OP_W-1:0] OP_FILL   = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic clr_wr;   // write one all-maximum row during the clearing pass
      logic capture;  // take the request beat and launch the row read
      logic eval;     // row data is back: find maximum and candidates
      logic commit;   // pick victim, write the row back, issue response
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last; // clearing pass is at its last row
   } dp_sts_type;

endpackage

// ----- sv/rrip_cache_replacement_core.sv -----
// top level of the srrip cache replacement core
// a request beat goes via the read and write states and the response register
//   to its strobe; busy holds off new requests over the read-modify-write of
//   one set row through the single read and single write port of the row ram.
//   reset: a clearing pass fills all SET_COUNT rows (1024) with the maximum
//   value; busy stays high until it ends. responses cannot be stalled
module rrip_cache_replacement_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [rrip_pkg::OP_W-1:0]  req_operation,
   input  logic [rrip_pkg::SET_W-1:0] req_set_index,
   input  logic [rrip_pkg::WAY_W-1:0] req_way_index,
   output logic                       rsp_valid,
   output logic [rrip_pkg::WAY_W-1:0] rsp_victim_way,
   output logic                       rsp_victim_valid
);

   import rrip_pkg::*;

   // command and status between the state machine and the datapath
   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: clearing pass, then idle / read / write per request beat
   rrip_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // row store, bit-plane maximum search, lowest-way pick and ageing
   rrip_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_set_index    (req_set_index),
      .req_way_index    (req_way_index),
      .rsp_valid        (rsp_valid),
      .rsp_victim_way   (rsp_victim_way),
      .rsp_victim_valid (rsp_victim_valid)
   );

endmodule

// ----- sv/rrip_ram.sv -----
// generic single write port, single read port ram with registered read
module rrip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rrip_ctrl.sv -----
// controller state machine for the rrip replacement core
module rrip_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  rrip_pkg::dp_sts_type sts,
   output rrip_pkg::dp_cmd_type cmd,
   output logic                 busy
);

   import rrip_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (start)        state_in = ST_READ;
         ST_READ:                    state_in = ST_WRITE;
         ST_WRITE:                   state_in = ST_IDLE;
         default:                    state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.clr_wr  = (state_ff == ST_CLEAR);
   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.eval    = (state_ff == ST_READ);
   assign cmd.commit  = (state_ff == ST_WRITE);
   assign busy        = (state_ff != ST_IDLE);

endmodule

// ----- sv/rrip_dp.sv -----
// datapath of the rrip replacement core: row store, victim search, ageing
module rrip_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  rrip_pkg::dp_cmd_type           cmd,
   output rrip_pkg::dp_sts_type           sts,
   input  logic [rrip_pkg::OP_W-1:0]      req_operation,
   input  logic [rrip_pkg::SET_W-1:0]     req_set_index,
   input  logic [rrip_pkg::WAY_W-1:0]     req_way_index,
   output logic                           rsp_valid,
   output logic [rrip_pkg::WAY_W-1:0]     rsp_victim_way,
   output logic                           rsp_victim_valid
);

   import rrip_pkg::*;

   // request beat
   logic [OP_W-1:0] op_ff;
   set_addr_type    set_ff;
   way_addr_type    way_ff;
   logic            wr_ok_ff;
   logic            vic_ff;

   // evaluation stage
   row_type         row_ff;
   way_mask_type    cand_ff;
   rrpv_val_type    maxv_ff;

   // clearing pass
   set_addr_type    clr_ff;

   // response
   logic             rsp_valid_ff;
   logic [WAY_W-1:0] rsp_way_ff;
   logic             rsp_vvalid_ff;

   logic            set_ok;
   logic            way_ok;
   row_type         rd_row;
   way_mask_type    cand;
   way_mask_type    hit_bit;
   rrpv_val_type    maxv;
   way_addr_type    victim;
   rrpv_val_type    diff;
   row_type         new_row;
   rrpv_val_type    lane;
   logic            ram_wr_en;
   set_addr_type    ram_wr_addr;
   row_type         ram_wr_data;

   assign set_ok = int'(req_set_index) < SET_COUNT;
   assign way_ok = int'(req_way_index) < WAY_COUNT;

   rrip_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SET_COUNT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (set_addr_type'(req_set_index)),
      .rd_data (rd_row)
   );

   // maximum value and the ways that hold it, one bit plane at a time
   always_comb begin
      cand    = '1;
      maxv    = '0;
      hit_bit = '0;
      for (int b = RRPV_BITS - 1; b >= 0; b--) begin
         for (int w = 0; w < WAY_COUNT; w++) begin
            hit_bit[w] = cand[w] & rd_row[w*RRPV_BITS + b];
         end
         maxv[b] = |hit_bit;
         if (|hit_bit) begin
            cand = hit_bit;
         end
      end
   end

   // lowest candidate way, ageing and update of the row
   always_comb begin
      victim  = '0;
      lane    = '0;
      diff    = RRPV_MAX - maxv_ff;
      new_row = row_ff;
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         if (cand_ff[w]) begin
            victim = way_addr_type'(w);
         end
      end
      for (int w = 0; w < WAY_COUNT; w++) begin
         lane = row_ff[w*RRPV_BITS +: RRPV_BITS];
         if (op_ff == OP_VICTIM) begin
            new_row[w*RRPV_BITS +: RRPV_BITS] = rrpv_val_type'(lane + diff);
         end else if (op_ff == OP_HIT && way_addr_type'(w) == way_ff) begin
            new_row[w*RRPV_BITS +: RRPV_BITS] = '0;
         end else if (op_ff == OP_FILL && way_addr_type'(w) == way_ff) begin
            new_row[w*RRPV_BITS +: RRPV_BITS] = RRPV_FILL;
         end
      end
   end

   always_comb begin
      if (cmd.clr_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '1;
      end else begin
         ram_wr_en   = cmd.commit && wr_ok_ff;
         ram_wr_addr = set_ff;
         ram_wr_data = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + set_addr_type'(1);
         end
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         set_ff   <= set_addr_type'(req_set_index);
         way_ff   <= way_addr_type'(req_way_index);
         vic_ff   <= set_ok && (req_operation == OP_VICTIM);
         wr_ok_ff <= set_ok && ((req_operation == OP_VICTIM) ||
                     (((req_operation == OP_HIT) || (req_operation == OP_FILL)) && way_ok));
      end
      if (cmd.eval) begin
         row_ff  <= rd_row;
         cand_ff <= cand;
         maxv_ff <= maxv;
      end
      if (cmd.commit) begin
         rsp_way_ff    <= vic_ff ? WAY_W'(victim) : '0;
         rsp_vvalid_ff <= vic_ff;
      end
   end

   assign sts.clr_last      = (clr_ff == set_addr_type'(SET_COUNT - 1));
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_victim_way    = rsp_way_ff;
   assign rsp_victim_valid  = rsp_vvalid_ff;

endmodule

// ----- sv/rrip_chk.sv -----
// port-level checker for the rrip replacement core and its bind
module rrip_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [rrip_pkg::WAY_W-1:0] rsp_victim_way,
   input logic                       rsp_victim_valid
);

   import rrip_pkg::*;

   // a taken beat makes the core busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after a request beat");

   // every taken beat gets its response strobe after the read and write states
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response strobe missing after a request beat");

   // responses come one at a time, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two response strobes in a row");

   // a response without a victim carries way zero
   a_no_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_victim_valid) |-> (rsp_victim_way == '0))
      else $error("non-victim response with a non-zero way");

endmodule

bind rrip_cache_replacement_core rrip_chk u_rrip_chk (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_victim_way   (rsp_victim_way),
   .rsp_victim_valid (rsp_victim_valid)
);

// ----- tb/tb_rrip_cache_replacement_core.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the srrip cache replacement core
module tb_rrip_cache_replacement_core;
   import rrip_pkg::*;

   // the one operation code the core leaves unused
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   // how long the run may take before it is called hung
   localparam int RUN_LIMIT_CYCLES = 60000;

   // one request beat as the driver presents it
   typedef struct {
      logic [OP_W-1:0]  operation;
      logic [SET_W-1:0] set_index;
      logic [WAY_W-1:0] way_index;
   } request_beat_type;

   // one response beat as the core should produce it
   typedef struct {
      logic [WAY_W-1:0] victim_way;
      logic             victim_valid;
   } victim_reply_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic [OP_W-1:0]  req_operation = '0;
   logic [SET_W-1:0] req_set_index = '0;
   logic [WAY_W-1:0] req_way_index = '0;
   logic             busy;
   logic             rsp_valid;
   logic [WAY_W-1:0] rsp_victim_way;
   logic             rsp_victim_valid;

   request_beat_type pending_requests[$];
   victim_reply_type expected_replies[$];
   // shadow copy of the per-set re-reference values
   rrpv_val_type     rrpv_shadow[SET_COUNT][WAY_COUNT];
   int               accepted_count = 0;
   int               total_requests = 0;
   int               error_count = 0;

   rrip_cache_replacement_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_set_index    (req_set_index),
      .req_way_index    (req_way_index),
      .rsp_valid        (rsp_valid),
      .rsp_victim_way   (rsp_victim_way),
      .rsp_victim_valid (rsp_victim_valid)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // srrip behaviour: victim search with ageing, hit promotion and fill insertion
   function automatic victim_reply_type srrip_predict(input logic [OP_W-1:0]  operation,
                                                      input logic [SET_W-1:0] set_index,
                                                      input logic [WAY_W-1:0] way_index);
      victim_reply_type reply;
      int               best_way;
      int               w;
      rrpv_val_type     best_val;
      rrpv_val_type     lag;
      reply.victim_way   = '0;
      reply.victim_valid = 1'b0;
      // a set beyond the array is ignored outright
      if (int'(set_index) < SET_COUNT) begin
         case (operation)
            OP_VICTIM: begin
               // largest value wins, the lowest way on a tie
               best_way = 0;
               best_val = rrpv_shadow[set_index][0];
               for (w = 1; w < WAY_COUNT; w++) begin
                  if (rrpv_shadow[set_index][w] > best_val) begin
                     best_val = rrpv_shadow[set_index][w];
                     best_way = w;
                  end
               end
               // age the whole set so that the victim lands on the maximum
               lag = RRPV_MAX - best_val;
               for (w = 0; w < WAY_COUNT; w++) begin
                  rrpv_shadow[set_index][w] = rrpv_shadow[set_index][w] + lag;
               end
               reply.victim_way   = WAY_W'(best_way);
               reply.victim_valid = 1'b1;
            end
            OP_HIT: begin
               if (int'(way_index) < WAY_COUNT) begin
                  rrpv_shadow[set_index][way_index] = '0;
               end
            end
            OP_FILL: begin
               if (int'(way_index) < WAY_COUNT) begin
                  rrpv_shadow[set_index][way_index] = RRPV_MAX - rrpv_val_type'(1);
               end
            end
            default: begin
               // unused code leaves the state alone
            end
         endcase
      end
      return reply;
   endfunction

   task automatic queue_request(input logic [OP_W-1:0]  operation,
                                input logic [SET_W-1:0] set_index,
                                input logic [WAY_W-1:0] way_index);
      request_beat_type beat;
      beat.operation = operation;
      beat.set_index = set_index;
      beat.way_index = way_index;
      pending_requests.push_back(beat);
      total_requests++;
   endtask

   // driver: a beat is taken at the edge where start is high and busy low;
   // start drops at random with a chance of 16 in a hundred, except over a
   // quiet stretch in the middle of the random part
   always @(posedge clock) begin : drive_requests
      request_beat_type  beat;
      victim_reply_type  reply;
      logic              quiet_window;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            beat  = pending_requests.pop_front();
            reply = srrip_predict(beat.operation, beat.set_index, beat.way_index);
            expected_replies.push_back(reply);
            accepted_count++;
         end
         quiet_window = (accepted_count >= 150) && (accepted_count < 260);
         if (pending_requests.size() != 0 &&
             (quiet_window || $urandom_range(0, 99) >= 16)) begin
            start         <= 1'b1;
            req_operation <= pending_requests[0].operation;
            req_set_index <= pending_requests[0].set_index;
            req_way_index <= pending_requests[0].way_index;
         end else begin
            // idle cycle: junk on the fields, which must be ignored
            start         <= 1'b0;
            req_operation <= OP_W'($urandom);
            req_set_index <= SET_W'($urandom);
            req_way_index <= WAY_W'($urandom);
         end
      end
   end

   // monitor: every strobe must match the oldest outstanding prediction
   always @(posedge clock) begin : check_replies
      victim_reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            $error("response beat with nothing outstanding: victim_way %0d victim_valid %0d",
                   rsp_victim_way, rsp_victim_valid);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_victim_way !== want.victim_way) begin
               $error("victim_way: expected %0d, got %0d", want.victim_way, rsp_victim_way);
               error_count++;
            end
            if (rsp_victim_valid !== want.victim_valid) begin
               $error("victim_valid: expected %0d, got %0d",
                      want.victim_valid, rsp_victim_valid);
               error_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int                s;
      int                w;
      int                n;
      int                pick;
      logic [SET_W-1:0]  set_pool[6];
      logic [SET_W-1:0]  set_index;
      logic [OP_W-1:0]   operation;

      for (s = 0; s < SET_COUNT; s++) begin
         for (w = 0; w < WAY_COUNT; w++) begin
            rrpv_shadow[s][w] = RRPV_MAX;
         end
      end

      // directed: fresh sets at both ends, hits at the way extremes, a fill at way 5,
      // the unused code, then a full set of fills aged by one victim search
      queue_request(OP_VICTIM, '0, '1);
      queue_request(OP_VICTIM, '1, '0);
      queue_request(OP_HIT, '0, '1);
      queue_request(OP_HIT, '0, '0);
      queue_request(OP_FILL, '0, 4'd5);
      queue_request(OP_VICTIM, '0, '0);
      queue_request(OP_SPARE, '1, '1);
      queue_request(OP_SPARE, '0, '0);
      for (w = 0; w < WAY_COUNT; w++) begin
         queue_request(OP_FILL, 10'd9, WAY_W'(w));
      end
      queue_request(OP_VICTIM, 10'd9, '1);

      // random: most beats on a small pool of sets so that hits, fills and
      // ageing pile up; the rest go anywhere in the array
      set_pool[0] = '0;
      set_pool[1] = '1;
      for (n = 2; n < 6; n++) begin
         set_pool[n] = SET_W'($urandom);
      end
      for (n = 0; n < 400; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            set_index = set_pool[$urandom_range(0, 5)];
         end else begin
            set_index = SET_W'($urandom);
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            operation = OP_VICTIM;
         end else if (pick < 75) begin
            operation = OP_HIT;
         end else if (pick < 95) begin
            operation = OP_FILL;
         end else begin
            operation = OP_SPARE;
         end
         queue_request(operation, set_index, WAY_W'($urandom));
      end

      // reset held first, then released; the clearing pass keeps busy high after it
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == total_requests);
      while (expected_replies.size() != 0) begin
         @(posedge clock);
      end
      // let any stray strobe show itself
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #(20 * RUN_LIMIT_CYCLES);
      $display("TB_ERROR");
      $finish;
   end

endmodule
